// ----- rtl/piecewise_uniform_sampler_core_macros.svh -----
// assertion macros used by the checker file
`ifndef PIECEWISE_UNIFORM_SAMPLER_CORE_MACROS_SVH
`define PIECEWISE_UNIFORM_SAMPLER_CORE_MACROS_SVH

// clocked check, off while reset is high
`define PUS_ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define PUS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/pus_pkg.sv -----
// shared types and constants of the piecewise uniform sampler
package pus_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS      = 16;

  localparam int REQ_W   = 1;
  localparam int ENTRY_W = 4;
  localparam int BP_W    = 32;
  localparam int WGT_W   = 16;
  localparam int RAND_W  = 16;
  localparam int PC_W    = 5;
  localparam int IVL_W   = 4;
  localparam int DIFF_W  = BP_W + 1;
  localparam int PROD_W  = DIFF_W + RAND_W + 1;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 1'b0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 1'b1;

  localparam logic [PC_W-1:0] PC_RESET = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_HI,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic start_sample;
    logic walk;
    logic cap_hi;
    logic mul;
    logic fin;
    logic cfg_write;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

endpackage

// ----- rtl/pus_ram.sv -----
// generic single write port, single read port ram with registered read
module pus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pus_controller.sv -----
// sequencing state machine of the sampler
module pus_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pus_pkg::REQ_W-1:0]     req_type,
  input  logic                          cfg_valid,
  input  pus_pkg::status_t              status,
  output logic                          busy,
  output logic                          cfg_ready,
  output pus_pkg::cmd_t                 cmd
);
  import pus_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && req_type == REQ_SAMPLE) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.hit) begin
          state_next = ST_HI;
        end
      end
      ST_HI:   state_next = ST_MUL;
      ST_MUL:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy             = (state != ST_IDLE);
    cfg_ready        = (state == ST_IDLE);
    cmd.load         = (state == ST_IDLE) && start && (req_type == REQ_LOAD);
    cmd.start_sample = (state == ST_IDLE) && start && (req_type == REQ_SAMPLE);
    cmd.walk         = (state == ST_WALK);
    cmd.cap_hi       = (state == ST_HI);
    cmd.mul          = (state == ST_MUL);
    cmd.fin          = (state == ST_FIN);
    cmd.cfg_write    = cfg_valid && (state == ST_IDLE);
  end

endmodule

// ----- rtl/pus_datapath.sv -----
// table storage, weight walk and interpolation datapath
module pus_datapath #(
  parameter int MAX_POINTS = pus_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pus_pkg::cmd_t                      cmd,
  output pus_pkg::status_t                   status,
  input  logic [pus_pkg::ENTRY_W-1:0]        entry_index,
  input  logic signed [pus_pkg::BP_W-1:0]    breakpoint,
  input  logic [pus_pkg::WGT_W-1:0]          weight,
  input  logic [pus_pkg::RAND_W-1:0]         rand_select,
  input  logic [pus_pkg::RAND_W-1:0]         rand_interp,
  input  logic [pus_pkg::PC_W-1:0]           cfg_data,
  output logic                               done,
  output logic signed [pus_pkg::BP_W-1:0]    sample_value,
  output logic [pus_pkg::IVL_W-1:0]          interval_index
);
  import pus_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int SUM_W = WGT_W + IDX_W;
  localparam int ROW_W = BP_W + WGT_W;

  logic [PC_W-1:0]   point_count;
  logic              cache_valid;
  logic [RAND_W-1:0] cached_fraction;
  logic [RAND_W-1:0] sel;
  logic [RAND_W-1:0] interp;
  logic [IDX_W-1:0]  last;
  logic [IDX_W-1:0]  last_next;
  logic [IDX_W-1:0]  cnt;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [IDX_W-1:0]  chosen;
  logic signed [BP_W-1:0]   lo;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] val;

  logic              ram_we;
  logic [IDX_W-1:0]  raddr;
  logic [ROW_W-1:0]  rdata;
  logic signed [BP_W-1:0] rd_bp;
  logic [WGT_W-1:0]  rd_w;

  // each row holds the breakpoint and the weight of the interval starting there
  pus_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(IDX_W'(entry_index)),
    .wdata({breakpoint, weight}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ram_we = cmd.load && (int'(entry_index) < MAX_POINTS);
  assign rd_bp  = rdata[ROW_W-1:WGT_W];
  assign rd_w   = rdata[WGT_W-1:0];

  // read ahead: entry cnt+1 is addressed while entry cnt is checked
  assign raddr    = cmd.walk ? IDX_W'(cnt + 1'b1) : '0;
  assign sum_next = sum + SUM_W'(rd_w);
  assign status.hit = (SUM_W'(sel) < sum_next) || (cnt == last);

  // clamp the breakpoint count into 2..MAX_POINTS, keep the last interval index
  always_comb begin
    if (point_count < 5'd2) begin
      last_next = '0;
    end else if (int'(point_count) > MAX_POINTS) begin
      last_next = IDX_W'(MAX_POINTS - 2);
    end else begin
      last_next = IDX_W'(point_count - 5'd2);
    end
  end

  assign val = PROD_W'(lo) + (prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count     <= PC_RESET;
      cache_valid     <= 1'b0;
      cached_fraction <= '0;
      done            <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cmd.cfg_write) begin
        point_count <= cfg_data;
      end
      if (cmd.start_sample) begin
        cache_valid     <= 1'b1;
        cached_fraction <= rand_interp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      sel    <= cache_valid ? cached_fraction : rand_select;
      interp <= rand_interp;
      last   <= last_next;
      cnt    <= '0;
      sum    <= '0;
    end
    if (cmd.walk) begin
      chosen <= cnt;
      lo     <= rd_bp;
      if (!status.hit) begin
        cnt <= IDX_W'(cnt + 1'b1);
        sum <= sum_next;
      end
    end
    if (cmd.cap_hi) begin
      diff <= DIFF_W'(rd_bp) - DIFF_W'(lo);
    end
    if (cmd.mul) begin
      prod <= PROD_W'($signed({1'b0, interp})) * PROD_W'(diff);
    end
    if (cmd.fin) begin
      sample_value   <= val[BP_W-1:0];
      interval_index <= IVL_W'(chosen);
    end
  end

endmodule

// ----- rtl/piecewise_uniform_sampler_core.sv -----
// top level of the piecewise uniform inverse cdf sampler
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------------
//   request  | start, busy              | req_type entry_index breakpoint weight
//            |                          | rand_select rand_interp
//   config   | cfg_valid, cfg_ready     | cfg_data (point_count)
//   result   | done (one-cycle strobe)  | sample_value interval_index
//
// a load is written in the cycle it is accepted and leaves busy low
// a sample stays busy while 1..point_count-1 table rows are walked one per cycle
// by the single table read port and then through the hi, mul and fin states; the result
// strobes in the first cycle with busy low, and a new item can be taken in that cycle
// synchronous reset clears control, cache and point_count (2); the table is not cleared
module piecewise_uniform_sampler_core #(
  parameter int MAX_POINTS = pus_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [pus_pkg::REQ_W-1:0]          req_type,
  input  logic [pus_pkg::ENTRY_W-1:0]        entry_index,
  input  logic signed [pus_pkg::BP_W-1:0]    breakpoint,
  input  logic [pus_pkg::WGT_W-1:0]          weight,
  input  logic [pus_pkg::RAND_W-1:0]         rand_select,
  input  logic [pus_pkg::RAND_W-1:0]         rand_interp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pus_pkg::PC_W-1:0]           cfg_data,
  output logic                               done,
  output logic signed [pus_pkg::BP_W-1:0]    sample_value,
  output logic [pus_pkg::IVL_W-1:0]          interval_index
);
  import pus_pkg::*;

  cmd_t    cmd;
  status_t status;

  pus_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .cfg_valid(cfg_valid),
    .status   (status),
    .busy     (busy),
    .cfg_ready(cfg_ready),
    .cmd      (cmd)
  );

  pus_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .entry_index   (entry_index),
    .breakpoint    (breakpoint),
    .weight        (weight),
    .rand_select   (rand_select),
    .rand_interp   (rand_interp),
    .cfg_data      (cfg_data),
    .done          (done),
    .sample_value  (sample_value),
    .interval_index(interval_index)
  );

endmodule

// ----- rtl/pus_checker.sv -----
// port-level checks of the sampler and their bind
`include "piecewise_uniform_sampler_core_macros.svh"

module pus_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [pus_pkg::REQ_W-1:0]     req_type,
  input logic                          done
);
  import pus_pkg::*;

  // a result only shows once the sample has finished
  `PUS_ASSERT_SYNC(a_done_idle, done |-> !busy, "result strobe while busy")
  // an accepted sample request has busy high in the following cycle
  `PUS_ASSERT_SYNC(a_sample_busy, (start && !busy && req_type == REQ_SAMPLE) |=> busy,
                   "sample item did not raise busy")
  // a load never makes a result and never blocks
  `PUS_ASSERT_SYNC(a_load_quiet, (start && !busy && req_type == REQ_LOAD) |=> (!busy && !done),
                   "load item caused busy or a result")
  // one result per sample, never back to back
  `PUS_ASSERT_ALWAYS(a_done_pulse, done |=> !done, "result strobe longer than one cycle")

endmodule

bind piecewise_uniform_sampler_core pus_checker u_pus_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .req_type(req_type),
  .done    (done)
);
